FILE: design/utd_pkg.sv
// ----------------------------------------------------------------------------
// utd_pkg
// Types and constants shared by the UTF-8 delimiter tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package utd_pkg;

  localparam int unsigned MaxDelims = 7;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CpWidth  = 21;
  localparam int unsigned CntW     = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 21;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegDelimCount = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDelim0     = 3'd1;

  // Result kinds.
  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;

  localparam logic [ByteW-1:0]   DotByte    = 8'h2E;
  localparam logic [CpWidth-1:0] EllipsisCp = 21'h002026;

  // UTF-8 byte classes.
  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContTag   = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Tag  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Tag  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Tag  = 8'hF0;

  // Byte positions of one decode window: up to three held bytes and the new one.
  localparam int unsigned NumPos = 4;

  // Result slots of one item, in the order in which results leave the block.
  localparam int unsigned NumEvents  = 10;
  localparam int unsigned EvPreDot0  = 0;
  localparam int unsigned EvPreDot1  = 1;
  localparam int unsigned EvPos0     = 2;
  localparam int unsigned EvDotClose = 6;
  localparam int unsigned EvEndDot0  = 7;
  localparam int unsigned EvEndDot1  = 8;
  localparam int unsigned EvEndClose = 9;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    ActNone,
    ActEmit,
    ActClose
  } utd_act_e;

  typedef struct packed {
    logic [NumPos-1:0][ByteW-1:0] bytes;
    logic [NumEvents-1:0]         res_valid;
    logic [NumEvents-1:0]         res_kind;
  } utd_entry_t;

  // Sequence length announced by a lead byte; anything else stands alone.
  function automatic logic [2:0] lead_len(logic [ByteW-1:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & Lead2Mask) == Lead2Tag) begin
      len = 3'd2;
    end else if ((b & Lead3Mask) == Lead3Tag) begin
      len = 3'd3;
    end else if ((b & Lead4Mask) == Lead4Tag) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: design/utd_if.sv
// ----------------------------------------------------------------------------
// utd_if
// Valid/ready channels of the tokenizer: input bytes, results, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface utd_in_if;
  import utd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             in_end;
  modport source (output valid, in_byte, in_end, input ready);
  modport sink   (input valid, in_byte, in_end, output ready);
endinterface

interface utd_out_if;
  import utd_pkg::*;
  logic             valid;
  logic             ready;
  logic             out_kind;
  logic [ByteW-1:0] out_byte;
  logic             out_last;
  modport source (output valid, out_kind, out_byte, out_last, input ready);
  modport sink   (input valid, out_kind, out_byte, out_last, output ready);
endinterface

interface utd_cfg_if;
  import utd_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  modport source (output valid, cfg_index, cfg_data, input ready);
  modport sink   (input valid, cfg_index, cfg_data, output ready);
endinterface

`default_nettype wire

FILE: design/utd_cfg.sv
// ----------------------------------------------------------------------------
// utd_cfg
// Delimiter register file with the in-use mask derived from the count.
// ----------------------------------------------------------------------------
`default_nettype none

module utd_cfg #(
  parameter int unsigned MAX_DELIMS = utd_pkg::MaxDelims
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  utd_cfg_if.sink                                     cfg_ch,
  output logic [MAX_DELIMS-1:0]                       delim_use_o,
  output logic [MAX_DELIMS-1:0][utd_pkg::CpWidth-1:0] delim_cp_o
);
  import utd_pkg::*;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_DELIMS);

  logic [CntW-1:0]                    count_q;
  logic [MAX_DELIMS-1:0][CpWidth-1:0] delim_q;
  logic [CntW-1:0]                    eff_count;
  logic                               wr;

  assign cfg_ch.ready = 1'b1;
  assign wr           = cfg_ch.valid & cfg_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      delim_q <= '0;
    end else if (wr) begin
      if (cfg_ch.cfg_index == RegDelimCount) begin
        count_q <= cfg_ch.cfg_data[CntW-1:0];
      end
      for (int i = 0; i < MAX_DELIMS; i++) begin
        if (cfg_ch.cfg_index == CfgIdxW'(RegDelim0 + i)) begin
          delim_q[i] <= cfg_ch.cfg_data[CpWidth-1:0];
        end
      end
    end
  end

  // A count above the number of registers uses all of them.
  assign eff_count = (count_q > MaxCnt) ? MaxCnt : count_q;

  always_comb begin
    for (int i = 0; i < MAX_DELIMS; i++) begin
      delim_use_o[i] = CntW'(i) < eff_count;
    end
  end

  assign delim_cp_o = delim_q;

endmodule

`default_nettype wire

FILE: design/utd_front.sv
// ----------------------------------------------------------------------------
// utd_front
// Takes one byte per cycle while the queue has room, decodes UTF-8 against
// the held bytes and lays out the results in fixed slots for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module utd_front #(
  parameter int unsigned MAX_DELIMS = utd_pkg::MaxDelims
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  utd_in_if.sink                                      in_ch,
  input  logic [MAX_DELIMS-1:0]                       delim_use_i,
  input  logic [MAX_DELIMS-1:0][utd_pkg::CpWidth-1:0] delim_cp_i,
  input  logic                                        q_full_i,
  output logic                                        push_o,
  output utd_pkg::utd_entry_t                         entry_o
);
  import utd_pkg::*;

  logic [2:0][ByteW-1:0] held_q, held_d;
  logic [1:0]            hc_q, hc_d;
  logic [2:0]            sl_q, sl_d;
  logic [1:0]            dr_q, dr_d;
  logic                  open_q, open_d;

  logic                         accept;
  logic [ByteW-1:0]             x;
  logic [NumPos-1:0][ByteW-1:0] qb;
  logic [NumPos-1:0]            sdel;
  logic                         dot_del;
  logic [CpWidth-1:0]           mb_cp;
  logic                         mb_stop;
  logic                         x_cont;
  logic                         x_dot;
  logic [2:0]                   lenx;
  logic [NumEvents-1:0]         res_valid;
  logic [NumEvents-1:0]         res_kind;

  function automatic logic is_delim(logic [CpWidth-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < MAX_DELIMS; i++) begin
      if (delim_use_i[i] && (delim_cp_i[i] == cp)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  assign in_ch.ready = ~q_full_i;
  assign accept      = in_ch.valid & in_ch.ready;
  assign x           = in_ch.in_byte;
  assign x_cont      = (x & ContMask) == ContTag;
  assign x_dot       = x == DotByte;
  assign lenx        = lead_len(x);

  // Decode window: the held bytes followed by the new byte.
  always_comb begin
    qb = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < hc_q) begin
        qb[i] = held_q[i];
      end
    end
    qb[hc_q] = x;
  end

  always_comb begin
    for (int i = 0; i < NumPos; i++) begin
      sdel[i] = is_delim({{(CpWidth-ByteW){1'b0}}, qb[i]});
    end
  end

  assign dot_del = is_delim({{(CpWidth-ByteW){1'b0}}, DotByte});

  always_comb begin
    unique case (sl_q)
      3'd2:    mb_cp = {10'b0, qb[0][4:0], qb[1][5:0]};
      3'd3:    mb_cp = {5'b0, qb[0][3:0], qb[1][5:0], qb[2][5:0]};
      3'd4:    mb_cp = {qb[0][2:0], qb[1][5:0], qb[2][5:0], qb[3][5:0]};
      default: mb_cp = {{(CpWidth-ByteW){1'b0}}, qb[0]};
    endcase
  end

  assign mb_stop = (mb_cp == EllipsisCp) || is_delim(mb_cp);

  always_comb begin
    utd_act_e   act_pos [NumPos];
    utd_act_e   act     [NumEvents];
    utd_act_e   pre0, pre1, dclose, end0, end1, endc;
    logic [1:0] dr_mid;
    logic       fresh;
    logic       open_c;

    for (int i = 0; i < NumPos; i++) begin
      act_pos[i] = ActNone;
    end
    pre0   = ActNone;
    pre1   = ActNone;
    dclose = ActNone;
    end0   = ActNone;
    end1   = ActNone;
    endc   = ActNone;
    held_d = held_q;
    hc_d   = hc_q;
    sl_d   = sl_q;
    dr_mid = dr_q;
    fresh  = 1'b1;

    if (hc_q != 2'd0) begin
      if (x_cont) begin
        fresh = 1'b0;
        if ((3'({1'b0, hc_q}) + 3'd1) == sl_q) begin
          // Sequence complete: one character of sl_q bytes.
          hc_d = 2'd0;
          sl_d = 3'd0;
          if (mb_stop) begin
            act_pos[0] = ActClose;
          end else begin
            for (int i = 0; i < NumPos; i++) begin
              if (3'(i) < sl_q) begin
                act_pos[i] = ActEmit;
              end
            end
          end
        end else if (in_ch.in_end) begin
          // Truncated: every byte of the window stands alone.
          hc_d = 2'd0;
          sl_d = 3'd0;
          for (int i = 0; i < NumPos; i++) begin
            if (2'(i) <= hc_q) begin
              act_pos[i] = sdel[i] ? ActClose : ActEmit;
            end
          end
        end else begin
          held_d[hc_q] = x;
          hc_d         = hc_q + 2'd1;
        end
      end else begin
        // Malformed: the held bytes stand alone, the new byte starts afresh.
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < hc_q) begin
            act_pos[i] = sdel[i] ? ActClose : ActEmit;
          end
        end
      end
    end

    if (fresh) begin
      hc_d = 2'd0;
      sl_d = 3'd0;
      if (x_dot) begin
        if (dot_del) begin
          dclose = ActClose;
          dr_mid = 2'd3;
        end else if (dr_q != 2'd3) begin
          dr_mid = dr_q + 2'd1;
          if (dr_q == 2'd2) begin
            dclose = ActClose;
          end
        end
      end else begin
        if ((dr_q == 2'd1) || (dr_q == 2'd2)) begin
          if (dot_del) begin
            pre0 = ActClose;
          end else begin
            pre0 = ActEmit;
            if (dr_q == 2'd2) begin
              pre1 = ActEmit;
            end
          end
        end
        dr_mid = 2'd0;
        if ((lenx != 3'd1) && !in_ch.in_end) begin
          held_d[0] = x;
          hc_d      = 2'd1;
          sl_d      = lenx;
        end else begin
          act_pos[hc_q] = sdel[hc_q] ? ActClose : ActEmit;
        end
      end
    end

    dr_d = dr_mid;
    if (in_ch.in_end) begin
      if ((dr_mid == 2'd1) || (dr_mid == 2'd2)) begin
        if (dot_del) begin
          end0 = ActClose;
        end else begin
          end0 = ActEmit;
          if (dr_mid == 2'd2) begin
            end1 = ActEmit;
          end
        end
      end
      endc = ActClose;
      hc_d = 2'd0;
      sl_d = 3'd0;
      dr_d = 2'd0;
    end

    act[EvPreDot0] = pre0;
    act[EvPreDot1] = pre1;
    for (int i = 0; i < NumPos; i++) begin
      act[EvPos0 + i] = act_pos[i];
    end
    act[EvDotClose] = dclose;
    act[EvEndDot0]  = end0;
    act[EvEndDot1]  = end1;
    act[EvEndClose] = endc;

    // A close only yields a result when the token holds bytes.
    open_c = open_q;
    for (int i = 0; i < NumEvents; i++) begin
      res_valid[i] = (act[i] == ActEmit) || ((act[i] == ActClose) && open_c);
      res_kind[i]  = (act[i] == ActClose) ? KindEnd : KindByte;
      if (act[i] == ActEmit) begin
        open_c = 1'b1;
      end else if (act[i] == ActClose) begin
        open_c = 1'b0;
      end
    end
    open_d = in_ch.in_end ? 1'b0 : open_c;
  end

  assign push_o            = accept & (|res_valid);
  assign entry_o.bytes     = qb;
  assign entry_o.res_valid = res_valid;
  assign entry_o.res_kind  = res_kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q   <= '0;
      sl_q   <= '0;
      dr_q   <= '0;
      open_q <= 1'b0;
    end else if (accept) begin
      hc_q   <= hc_d;
      sl_q   <= sl_d;
      dr_q   <= dr_d;
      open_q <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/utd_fifo.sv
// ----------------------------------------------------------------------------
// utd_fifo
// Short queue of result slot entries between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module utd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  utd_pkg::utd_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output utd_pkg::utd_entry_t head_o
);
  import utd_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  utd_entry_t      mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = count_q == (PtrW+1)'(QueueDepth);
  assign empty_o = count_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/utd_back.sv
// ----------------------------------------------------------------------------
// utd_back
// Walks the valid slots of each queued entry and sends one result per cycle
// while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module utd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  utd_pkg::utd_entry_t head_i,
  output logic                pop_o,
  utd_out_if.source           out_ch
);
  import utd_pkg::*;

  logic [NumPos-1:0][ByteW-1:0] bytes_q;
  logic [NumEvents-1:0]         kind_q;
  logic [NumEvents-1:0]         mask_q;
  logic [NumEvents-1:0]         mask_next;
  logic [NumEvents-1:0]         sel;
  logic                         adv;
  logic                         emit;
  logic                         sel_kind;
  logic [ByteW-1:0]             sel_byte;
  logic                         sel_last;

  logic             out_valid_q;
  logic             out_kind_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_last_q;

  assign adv  = ~out_valid_q | out_ch.ready;
  assign emit = adv & (|mask_q);

  // Lowest pending slot goes first.
  assign sel      = mask_q & (~mask_q + NumEvents'(1));
  assign sel_last = (mask_q & ~sel) == '0;
  assign sel_kind = |(sel & kind_q);

  always_comb begin
    sel_byte = DotByte;
    for (int i = 0; i < NumPos; i++) begin
      if (sel[EvPos0 + i]) begin
        sel_byte = bytes_q[i];
      end
    end
    if (sel_kind == KindEnd) begin
      sel_byte = '0;
    end
  end

  assign mask_next = emit ? (mask_q & ~sel) : mask_q;
  assign pop_o     = (mask_next == '0) & ~empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= pop_o ? head_i.res_valid : mask_next;
      if (adv) begin
        out_valid_q <= |mask_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bytes_q <= head_i.bytes;
      kind_q  <= head_i.res_kind;
    end
    if (emit) begin
      out_kind_q <= sel_kind;
      out_byte_q <= sel_byte;
      out_last_q <= sel_last;
    end
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.out_kind = out_kind_q;
  assign out_ch.out_byte = out_byte_q;
  assign out_ch.out_last = out_last_q;

endmodule

`default_nettype wire

FILE: design/utf8_delimiter_tokenizer.sv
// ----------------------------------------------------------------------------
// utf8_delimiter_tokenizer
// Splits a UTF-8 byte stream into tokens at configured delimiter code points,
// at U+2026 and at runs of three or more dots.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one string byte per item; in_end marks the last byte.
//   out_ch carries results: a token byte (out_kind 0) or the end of a
//          nonempty token (out_kind 1); out_last flags the final result
//          caused by one input item. An item may cause no result at all.
//   cfg_ch writes register 0 (delimiter count) or 1..7 (delimiter code
//          points); write only while idle, which the block does not check.
// Timing: one input byte is accepted per cycle while the four-entry queue
//   between the decoder and the result sequencer has room. An accepted item
//   passes the queue, the sequencer's slot mask and the output register
//   before its first result appears; the sequencer sends one result per
//   cycle while the receiver is ready. A stalled receiver holds the output
//   register, then fills the queue, and only then is in_ch.ready dropped.
// Reset clears the registers, the decode state and the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_delimiter_tokenizer #(
  parameter int unsigned MAX_DELIMS = utd_pkg::MaxDelims
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  utd_in_if.sink    in_ch,
  utd_out_if.source out_ch,
  utd_cfg_if.sink   cfg_ch
);
  import utd_pkg::*;

  logic [MAX_DELIMS-1:0]              delim_use;
  logic [MAX_DELIMS-1:0][CpWidth-1:0] delim_cp;
  logic                               q_full;
  logic                               q_empty;
  logic                               push;
  logic                               pop;
  utd_entry_t                         push_entry;
  utd_entry_t                         head_entry;

  utd_cfg #(
    .MAX_DELIMS (MAX_DELIMS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_ch      (cfg_ch),
    .delim_use_o (delim_use),
    .delim_cp_o  (delim_cp)
  );

  utd_front #(
    .MAX_DELIMS (MAX_DELIMS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .delim_use_i (delim_use),
    .delim_cp_i  (delim_cp),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  utd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head_entry)
  );

  utd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (head_entry),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
